/* rtl/svm_pkg.sv */
// shared types and constants for the stack machine execute core
// opcode, status and state encodings, controller/datapath handshake structs
// no dependencies
package svm_pkg;

	localparam int MEM_WORDS = 4096;
	localparam int MEM_AW = $clog2(MEM_WORDS);
	localparam logic [16:0] MEM_BYTES = 17'(MEM_WORDS * 8);
	localparam int CODE_AW = 16;
	localparam int SP_W = 16;
	localparam int WORD_W = 64;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 168;

	typedef enum logic [5:0] {
		OP_LEA = 6'd0, OP_IMM, OP_JMP, OP_CALL, OP_JZ, OP_JNZ, OP_ENT, OP_ADJ,
		OP_LEV, OP_LI, OP_LC, OP_SI, OP_SC, OP_PUSH, OP_OR, OP_XOR, OP_AND,
		OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD,
		OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OPEN, OP_READ, OP_CLOS, OP_PRTF,
		OP_MALC, OP_MSET, OP_MCMP, OP_EXIT
	} op_t;

	typedef enum logic [2:0] {
		STS_OK = 3'd0, STS_HALT, STS_BADOP, STS_DIVZ, STS_BADADDR, STS_HOST
	} status_t;

	typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_MOD} md_kind_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_MD, S_WB
	} fsm_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic rd1;
		logic rd2;
		logic exec;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic use_md;
		logic md_done;
		logic out_free;
	} sts_t;

endpackage

/* rtl/svm_ram.sv */
// generic single-port ram with registered read
// no dependencies
module svm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/svm_muldiv.sv */
// shared radix-2 multiply / divide unit, one bit per cycle
// depends on svm_pkg
module svm_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  svm_pkg::md_kind_t kind,
	input  logic [63:0]       opa,
	input  logic [63:0]       opb,
	output logic              done,
	output logic [63:0]       result
);
	import svm_pkg::*;

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	md_kind_t    kind_q;
	logic [63:0] x_q, y_q, z_q;
	logic        negq_q, negr_q;
	logic [64:0] rem_sh;
	logic [64:0] rem_sub;

	assign rem_sh = {z_q, x_q[63]};
	assign rem_sub = rem_sh - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= kind;
			z_q    <= '0;
			negq_q <= opa[63] ^ opb[63];
			negr_q <= opa[63];
			if (kind == MD_MUL) begin
				x_q <= opa;
				y_q <= opb;
			end else begin
				x_q <= opa[63] ? (64'd0 - opa) : opa;
				y_q <= opb[63] ? (64'd0 - opb) : opb;
			end
		end else if (busy_q) begin
			if (kind_q == MD_MUL) begin
				if (y_q[0]) begin
					z_q <= z_q + x_q;
				end
				x_q <= {x_q[62:0], 1'b0};
				y_q <= {1'b0, y_q[63:1]};
			end else if (!rem_sub[64]) begin
				// restoring step, quotient bits shift into x
				z_q <= rem_sub[63:0];
				x_q <= {x_q[62:0], 1'b1};
			end else begin
				z_q <= rem_sh[63:0];
				x_q <= {x_q[62:0], 1'b0};
			end
		end
	end

	always_comb begin
		unique case (kind_q)
			MD_DIV:  result = negq_q ? (64'd0 - x_q) : x_q;
			MD_MOD:  result = negr_q ? (64'd0 - z_q) : z_q;
			default: result = z_q;
		endcase
	end

	assign done = done_q;
endmodule

/* rtl/svm_ctrl.sv */
// controller state machine for the execute core
// depends on svm_pkg
module svm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  svm_pkg::sts_t sts,
	output svm_pkg::cmd_t cmd,
	output svm_pkg::fsm_t state
);
	import svm_pkg::*;

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:  if (s_tvalid) state_d = S_RD1;
			S_RD1:   state_d = S_RD2;
			S_RD2:   state_d = S_EXEC;
			S_EXEC:  state_d = sts.use_md ? S_MD : S_WB;
			S_MD:    if (sts.md_done) state_d = S_WB;
			S_WB:    if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_RD1:   cmd.rd1 = 1'b1;
			S_RD2:   cmd.rd2 = 1'b1;
			S_EXEC:  cmd.exec = 1'b1;
			S_WB:    cmd.commit = sts.out_free;
			default: cmd = '0;
		endcase
	end

	assign state = state_q;
endmodule

/* rtl/svm_datapath.sv */
// datapath: machine registers, stack memory, alu, result register
// depends on svm_pkg, svm_ram, svm_muldiv
module svm_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  svm_pkg::cmd_t                     cmd,
	output svm_pkg::sts_t                     sts,
	input  logic [svm_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                              cfg_wr,
	input  logic [15:0]                       cfg_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [svm_pkg::M_TDATA_W-1:0]     m_tdata
);
	import svm_pkg::*;

	// machine state
	logic [63:0]        ax_q;
	logic [SP_W-1:0]    sp_q, bp_q;
	logic [CODE_AW-1:0] pc_q;
	logic               halt_q;
	logic [MEM_AW-1:0]  clr_cnt_q;
	// instruction in flight
	logic [5:0]         op_q;
	logic [63:0]        imm_q, t_q;
	// results waiting for commit
	logic [63:0]        res_acc_q, res_exit_q, res_wdata_q;
	logic [SP_W-1:0]    res_sp_q, res_bp_q;
	logic [CODE_AW-1:0] res_npc_q;
	status_t            res_status_q;
	logic               res_halt_q, res_we_q;
	logic [MEM_AW-1:0]  res_waddr_q;
	// output register
	logic               out_valid_q;
	logic [63:0]        out_acc_q, out_exit_q;
	logic [SP_W-1:0]    out_sp_q;
	logic [CODE_AW-1:0] out_npc_q;
	status_t            out_status_q;

	logic [63:0]        rdata;
	logic [MEM_AW-1:0]  ram_addr, addr1, addr2;
	logic               ram_we;
	logic [63:0]        ram_wdata;
	logic               md_done;
	logic [63:0]        md_result;

	logic [63:0]        n_acc, n_exit, n_wdata;
	logic [SP_W-1:0]    n_sp, n_bp;
	logic [CODE_AW-1:0] n_npc, pc1, pc2;
	status_t            n_status;
	logic               n_halt, n_we, n_use_md;
	logic [MEM_AW-1:0]  n_waddr;
	md_kind_t           n_kind;

	logic [SP_W-1:0]    sp_m8;
	logic               sp_ge8, sp_wok, ax_wok, bp_ok, imm_code_ok;
	logic signed [65:0] ent_diff, adj_sum;
	logic [7:0]         lc_byte;
	logic [63:0]        sc_word;
	logic [63:0]        sx_imm;

	assign pc1 = pc_q + CODE_AW'(1);
	assign pc2 = pc_q + CODE_AW'(2);
	assign sp_m8 = sp_q - SP_W'(8);
	assign sp_ge8 = |sp_q[SP_W-1:3];
	assign sp_wok = (sp_q[2:0] == 3'd0) && ({1'b0, sp_q} < MEM_BYTES);
	assign ax_wok = (ax_q[2:0] == 3'd0) && (ax_q < 64'(MEM_BYTES));
	assign bp_ok = (bp_q[2:0] == 3'd0) && (({1'b0, bp_q} + 17'd8) < MEM_BYTES);
	assign imm_code_ok = (imm_q[63:CODE_AW] == '0);
	assign sx_imm = imm_q;
	assign ent_diff = $signed({53'd0, sp_m8[SP_W-1:3]}) - $signed({{2{sx_imm[63]}}, sx_imm});
	assign adj_sum = $signed({53'd0, sp_q[SP_W-1:3]}) + $signed({{2{sx_imm[63]}}, sx_imm});
	assign lc_byte = 8'(t_q >> {ax_q[2:0], 3'b000});

	// byte merge for a character store, target word is the second read
	always_comb begin
		sc_word = rdata;
		for (int i = 0; i < 8; i++) begin
			if (t_q[2:0] == 3'(i)) begin
				sc_word[i*8 +: 8] = ax_q[7:0];
			end
		end
	end

	always_comb begin
		unique case (op_q)
			OP_LEV:       addr1 = bp_q[MEM_AW+2:3];
			OP_LI, OP_LC: addr1 = ax_q[MEM_AW+2:3];
			default:      addr1 = sp_q[MEM_AW+2:3];
		endcase
		if (op_q == OP_LEV) begin
			addr2 = bp_q[MEM_AW+2:3] + MEM_AW'(1);
		end else begin
			addr2 = rdata[MEM_AW+2:3];
		end
	end

	always_comb begin
		n_acc    = ax_q;
		n_sp     = sp_q;
		n_bp     = bp_q;
		n_npc    = pc_q;
		n_exit   = '0;
		n_status = STS_OK;
		n_halt   = halt_q;
		n_we     = 1'b0;
		n_waddr  = sp_m8[MEM_AW+2:3];
		n_wdata  = ax_q;
		n_use_md = 1'b0;
		n_kind   = MD_MUL;
		if (halt_q) begin
			n_status = STS_HALT;
		end else begin
			unique case (op_q)
				OP_LEA: begin
					n_acc = {48'd0, bp_q} + {imm_q[60:0], 3'b000};
					n_npc = pc2;
				end
				OP_IMM: begin
					n_acc = imm_q;
					n_npc = pc2;
				end
				OP_JMP, OP_JZ, OP_JNZ: begin
					if ((op_q == OP_JZ && ax_q != '0) || (op_q == OP_JNZ && ax_q == '0)) begin
						n_npc = pc2;
					end else if (imm_code_ok) begin
						n_npc = imm_q[CODE_AW-1:0];
					end else begin
						n_status = STS_BADADDR;
					end
				end
				OP_CALL: begin
					if (!imm_code_ok || !sp_ge8) begin
						n_status = STS_BADADDR;
					end else begin
						n_we    = 1'b1;
						n_wdata = {48'd0, pc2};
						n_sp    = sp_m8;
						n_npc   = imm_q[CODE_AW-1:0];
					end
				end
				OP_ENT: begin
					if (!sp_ge8 || ent_diff[65] || (ent_diff[64:0] > 65'(MEM_WORDS))) begin
						n_status = STS_BADADDR;
					end else begin
						n_we    = 1'b1;
						n_wdata = {48'd0, bp_q};
						n_bp    = sp_m8;
						n_sp    = {ent_diff[SP_W-4:0], 3'b000};
						n_npc   = pc2;
					end
				end
				OP_ADJ: begin
					if (adj_sum[65] || (adj_sum[64:0] > 65'(MEM_WORDS))) begin
						n_status = STS_BADADDR;
					end else begin
						n_sp  = {adj_sum[SP_W-4:0], 3'b000};
						n_npc = pc2;
					end
				end
				OP_LEV: begin
					if (!bp_ok || (t_q[2:0] != 3'd0) || (t_q > 64'(MEM_BYTES))
						|| (rdata[63:CODE_AW] != '0)) begin
						n_status = STS_BADADDR;
					end else begin
						n_bp  = t_q[SP_W-1:0];
						n_sp  = bp_q + SP_W'(16);
						n_npc = rdata[CODE_AW-1:0];
					end
				end
				OP_LI: begin
					if (!ax_wok) begin
						n_status = STS_BADADDR;
					end else begin
						n_acc = t_q;
						n_npc = pc1;
					end
				end
				OP_LC: begin
					if (ax_q >= 64'(MEM_BYTES)) begin
						n_status = STS_BADADDR;
					end else begin
						n_acc = {{56{lc_byte[7]}}, lc_byte};
						n_npc = pc1;
					end
				end
				OP_SI, OP_SC: begin
					if (!sp_wok || (t_q >= 64'(MEM_BYTES))
						|| (op_q == OP_SI && t_q[2:0] != 3'd0)) begin
						n_status = STS_BADADDR;
					end else begin
						n_we    = 1'b1;
						n_waddr = t_q[MEM_AW+2:3];
						if (op_q == OP_SC) begin
							n_wdata = sc_word;
							n_acc   = {{56{ax_q[7]}}, ax_q[7:0]};
						end
						n_sp  = sp_q + SP_W'(8);
						n_npc = pc1;
					end
				end
				OP_PUSH: begin
					if (!sp_ge8) begin
						n_status = STS_BADADDR;
					end else begin
						n_we  = 1'b1;
						n_sp  = sp_m8;
						n_npc = pc1;
					end
				end
				OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE,
				OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
					if (!sp_wok) begin
						n_status = STS_BADADDR;
					end else if ((op_q == OP_DIV || op_q == OP_MOD) && ax_q == '0) begin
						n_status = STS_DIVZ;
					end else begin
						n_sp  = sp_q + SP_W'(8);
						n_npc = pc1;
						unique case (op_q)
							OP_OR:   n_acc = t_q | ax_q;
							OP_XOR:  n_acc = t_q ^ ax_q;
							OP_AND:  n_acc = t_q & ax_q;
							OP_EQ:   n_acc = {63'd0, t_q == ax_q};
							OP_NE:   n_acc = {63'd0, t_q != ax_q};
							OP_LT:   n_acc = {63'd0, $signed(t_q) < $signed(ax_q)};
							OP_GT:   n_acc = {63'd0, $signed(ax_q) < $signed(t_q)};
							OP_LE:   n_acc = {63'd0, !($signed(ax_q) < $signed(t_q))};
							OP_GE:   n_acc = {63'd0, !($signed(t_q) < $signed(ax_q))};
							OP_SHL:  n_acc = t_q << ax_q[5:0];
							OP_SHR:  n_acc = $unsigned($signed(t_q) >>> ax_q[5:0]);
							OP_ADD:  n_acc = t_q + ax_q;
							OP_SUB:  n_acc = t_q - ax_q;
							OP_MUL: begin
								n_use_md = 1'b1;
								n_kind   = MD_MUL;
							end
							OP_DIV: begin
								n_use_md = 1'b1;
								n_kind   = MD_DIV;
							end
							default: begin
								n_use_md = 1'b1;
								n_kind   = MD_MOD;
							end
						endcase
					end
				end
				OP_OPEN, OP_READ, OP_CLOS, OP_PRTF, OP_MALC, OP_MSET, OP_MCMP: begin
					n_status = STS_HOST;
				end
				OP_EXIT: begin
					if (!sp_wok) begin
						n_status = STS_BADADDR;
					end else begin
						n_exit   = t_q;
						n_halt   = 1'b1;
						n_status = STS_HALT;
					end
				end
				default: n_status = STS_BADOP;
			endcase
		end
	end

	svm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exec && n_use_md),
		.kind   (n_kind),
		.opa    (t_q),
		.opb    (ax_q),
		.done   (md_done),
		.result (md_result)
	);

	always_comb begin
		priority if (cmd.clr) begin
			ram_addr = clr_cnt_q;
		end else if (cmd.rd1) begin
			ram_addr = addr1;
		end else if (cmd.rd2) begin
			ram_addr = addr2;
		end else begin
			ram_addr = res_waddr_q;
		end
	end

	assign ram_we = cmd.clr || (cmd.commit && res_we_q);
	assign ram_wdata = cmd.clr ? 64'd0 : res_wdata_q;

	svm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (cmd.rd1 || cmd.rd2),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q        <= '0;
			sp_q        <= MEM_BYTES[SP_W-1:0];
			bp_q        <= MEM_BYTES[SP_W-1:0];
			pc_q        <= '0;
			halt_q      <= 1'b0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
			end
			if (cfg_wr) begin
				pc_q <= cfg_data;
			end
			if (cmd.commit) begin
				ax_q        <= res_acc_q;
				sp_q        <= res_sp_q;
				bp_q        <= res_bp_q;
				pc_q        <= res_npc_q;
				halt_q      <= res_halt_q;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_tdata[5:0];
			imm_q <= s_tdata[69:6];
		end
		if (cmd.rd2) begin
			t_q <= rdata;
		end
		if (cmd.exec) begin
			res_acc_q    <= n_acc;
			res_sp_q     <= n_sp;
			res_bp_q     <= n_bp;
			res_npc_q    <= n_npc;
			res_exit_q   <= n_exit;
			res_status_q <= n_status;
			res_halt_q   <= n_halt;
			res_we_q     <= n_we;
			res_waddr_q  <= n_waddr;
			res_wdata_q  <= n_wdata;
		end
		if (md_done) begin
			res_acc_q <= md_result;
		end
		if (cmd.commit) begin
			out_acc_q    <= res_acc_q;
			out_sp_q     <= res_sp_q;
			out_npc_q    <= res_npc_q;
			out_exit_q   <= res_exit_q;
			out_status_q <= res_status_q;
		end
	end

	assign sts.clr_last = &clr_cnt_q;
	assign sts.use_md   = n_use_md;
	assign sts.md_done  = md_done;
	assign sts.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_status_q, out_exit_q, out_npc_q, out_sp_q, out_acc_q};
endmodule

/* rtl/stack_vm_instruction_execute_core.sv */
// top level of the stack machine execute core
// depends on svm_pkg, svm_ctrl, svm_datapath
//
// executes one instruction per input item against accumulator, stack and
// frame pointers, program counter and a 4096-word stack memory.
// s_* channel: one instruction per item; m_* channel: one result per item.
// cfg_* channel: writes the start program counter, to be written only while
// idle; cfg_ready is always high and a write also loads the program counter.
// after reset the memory is cleared one word a cycle, during which s_tready
// stays low; machine registers take their reset values at once.
// an instruction goes through two stack memory reads, execute and write
// back; mul, div and mod also go through a bit-serial unit between execute
// and write back. one item is worked on at a time; the single memory port
// and the 64-step multiply/divide unit bound how fast items go through.
// a finished result sits in the output register; the next item is taken
// and worked on meanwhile, and only its write back waits on m_tready.
module stack_vm_instruction_execute_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [svm_pkg::S_TDATA_W-1:0]     s_tdata,  // op[5:0], imm[69:6]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// acc[63:0], stack_ptr[79:64], next_pc[95:80], exit_value[159:96], status[162:160]
	output logic [svm_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [15:0]                       cfg_data
);
	import svm_pkg::*;

	cmd_t cmd;
	sts_t sts;
	fsm_t state;

	assign cfg_ready = 1'b1;

	svm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	svm_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// no item taken while the memory clear is running
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !(s_tvalid && s_tready))
		else $error("item accepted during memory clear");

	// write back never overwrites a result still waiting
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid || m_tready))
		else $error("result overwritten");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	a_md_to_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_MD && sts.md_done) |=> state == S_WB)
		else $error("multiply/divide result not written back");
endmodule

/* tb/tb.sv */
// testbench for the stack machine execute core: directed and random instruction
// streams checked item by item against a predictor kept inside the bench
// depends on svm_pkg and stack_vm_instruction_execute_core
`timescale 1ns / 1ps

module tb;
	import svm_pkg::*;

	typedef struct {
		logic [63:0] acc;
		logic [15:0] sp;
		logic [15:0] npc;
		logic [63:0] exitv;
		logic [2:0]  status;
	} vm_result_t;

	localparam logic [63:0] WORD_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] WORD_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] TOP = 64'd32768;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;  // op[5:0], imm[69:6]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// acc[63:0], stack_ptr[79:64], next_pc[95:80], exit_value[159:96], status[162:160]
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [15:0]           cfg_data = '0;

	// machine state as predicted
	logic [63:0] vm_acc, vm_sp, vm_bp, vm_pc;
	logic [63:0] vm_mem [0:4095];
	logic        vm_halted;

	vm_result_t  pending_results[$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	int          cycles = 0;
	logic [9:0]  rx_phase = '0;

	stack_vm_instruction_execute_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 800000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver stall pattern: free running, random light, random heavy, slow toggle
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1'b1;
		case (rx_phase[9:8])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= rx_phase[4];
		endcase
	end

	always @(posedge clk) begin
		vm_result_t e;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: %h", m_tdata);
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				if (m_tdata[63:0] !== e.acc) begin
					$error("acc expected %h actual %h", e.acc, m_tdata[63:0]);
					mismatches++;
				end
				if (m_tdata[79:64] !== e.sp) begin
					$error("stack_ptr expected %h actual %h", e.sp, m_tdata[79:64]);
					mismatches++;
				end
				if (m_tdata[95:80] !== e.npc) begin
					$error("next_pc expected %h actual %h", e.npc, m_tdata[95:80]);
					mismatches++;
				end
				if (m_tdata[159:96] !== e.exitv) begin
					$error("exit_value expected %h actual %h", e.exitv, m_tdata[159:96]);
					mismatches++;
				end
				if (m_tdata[162:160] !== e.status) begin
					$error("status expected %0d actual %0d", e.status, m_tdata[162:160]);
					mismatches++;
				end
			end
		end
	end

	function automatic logic word_ok(logic [63:0] a);
		return a[2:0] == 3'd0 && a < TOP;
	endfunction

	// executes one instruction on the predicted machine state
	task automatic execute_instr(input logic [5:0] op, input logic [63:0] imm,
			output vm_result_t r);
		logic [63:0] ax, sp, bp, npc, exitv, pc1, pc2, t, res, a, w, nbp, rpc, qa, qb;
		logic [2:0]  st;
		logic        take;
		longint      s, bw, sw;
		ax = vm_acc; sp = vm_sp; bp = vm_bp;
		npc = vm_pc; exitv = '0; st = STS_OK; res = '0;
		pc1 = {48'd0, 16'(vm_pc + 1)};
		pc2 = {48'd0, 16'(vm_pc + 2)};
		s = $signed(imm);
		if (vm_halted) begin
			st = STS_HALT;
		end else begin
			case (op)
				OP_LEA: begin vm_acc = bp + (imm << 3); npc = pc2; end
				OP_IMM: begin vm_acc = imm; npc = pc2; end
				OP_JMP, OP_JZ, OP_JNZ: begin
					take = op == OP_JMP || (op == OP_JZ && ax == 0) || (op == OP_JNZ && ax != 0);
					if (!take) npc = pc2;
					else if (imm < 64'd65536) npc = imm;
					else st = STS_BADADDR;
				end
				OP_CALL: begin
					if (imm >= 64'd65536 || sp < 8) begin
						st = STS_BADADDR;
					end else begin
						sp = sp - 8;
						vm_mem[sp[14:3]] = pc2;
						vm_sp = sp;
						npc = imm;
					end
				end
				OP_ENT: begin
					if (sp < 8) begin
						st = STS_BADADDR;
					end else begin
						bw = longint'((sp - 8) >> 3);
						if (s > bw || s < bw - 4096) begin
							st = STS_BADADDR;
						end else begin
							vm_mem[(sp - 64'd8) >> 3] = bp;
							vm_bp = sp - 8;
							vm_sp = 64'(bw - s) * 8;
							npc = pc2;
						end
					end
				end
				OP_ADJ: begin
					sw = longint'(sp >> 3);
					if (s > 4096 - sw || s < -sw) begin
						st = STS_BADADDR;
					end else begin
						vm_sp = 64'(sw + s) * 8;
						npc = pc2;
					end
				end
				OP_LEV: begin
					if (!word_ok(bp) || !word_ok(bp + 8)) begin
						st = STS_BADADDR;
					end else begin
						nbp = vm_mem[bp[14:3]];
						rpc = vm_mem[(bp + 64'd8) >> 3];
						if (nbp[2:0] != 0 || nbp > TOP || rpc >= 64'd65536) begin
							st = STS_BADADDR;
						end else begin
							vm_bp = nbp;
							vm_sp = bp + 16;
							npc = rpc;
						end
					end
				end
				OP_LI: begin
					if (!word_ok(ax)) st = STS_BADADDR;
					else begin vm_acc = vm_mem[ax[14:3]]; npc = pc1; end
				end
				OP_LC: begin
					if (ax >= TOP) begin
						st = STS_BADADDR;
					end else begin
						w = vm_mem[ax[14:3]] >> (ax[2:0] * 8);
						vm_acc = {{56{w[7]}}, w[7:0]};
						npc = pc1;
					end
				end
				OP_SI, OP_SC: begin
					if (!word_ok(sp)) begin
						st = STS_BADADDR;
					end else begin
						a = vm_mem[sp[14:3]];
						if ((op == OP_SI && !word_ok(a)) || (op == OP_SC && a >= TOP)) begin
							st = STS_BADADDR;
						end else begin
							if (op == OP_SI) begin
								vm_mem[a[14:3]] = ax;
							end else begin
								w = vm_mem[a[14:3]];
								w[a[2:0]*8 +: 8] = ax[7:0];
								vm_mem[a[14:3]] = w;
								vm_acc = {{56{ax[7]}}, ax[7:0]};
							end
							vm_sp = sp + 8;
							npc = pc1;
						end
					end
				end
				OP_PUSH: begin
					if (sp < 8) begin
						st = STS_BADADDR;
					end else begin
						sp = sp - 8;
						vm_mem[sp[14:3]] = ax;
						vm_sp = sp;
						npc = pc1;
					end
				end
				OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE,
				OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
					if (!word_ok(sp)) begin
						st = STS_BADADDR;
					end else begin
						t = vm_mem[sp[14:3]];
						qa = t[63] ? -t : t;
						qb = ax[63] ? -ax : ax;
						case (op)
							OP_OR:  res = t | ax;
							OP_XOR: res = t ^ ax;
							OP_AND: res = t & ax;
							OP_EQ:  res = 64'(t == ax);
							OP_NE:  res = 64'(t != ax);
							OP_LT:  res = 64'($signed(t) < $signed(ax));
							OP_GT:  res = 64'($signed(t) > $signed(ax));
							OP_LE:  res = 64'($signed(t) <= $signed(ax));
							OP_GE:  res = 64'($signed(t) >= $signed(ax));
							OP_SHL: res = t << ax[5:0];
							OP_SHR: res = $signed(t) >>> ax[5:0];
							OP_ADD: res = t + ax;
							OP_SUB: res = t - ax;
							OP_MUL: res = t * ax;
							default: begin
								if (ax == 0) begin
									st = STS_DIVZ;
								end else if (op == OP_DIV) begin
									res = qa / qb;
									if (t[63] ^ ax[63]) res = -res;
								end else begin
									res = qa % qb;
									if (t[63]) res = -res;
								end
							end
						endcase
						if (st == STS_OK) begin
							vm_acc = res;
							vm_sp = sp + 8;
							npc = pc1;
						end
					end
				end
				OP_OPEN, OP_READ, OP_CLOS, OP_PRTF, OP_MALC, OP_MSET, OP_MCMP: st = STS_HOST;
				OP_EXIT: begin
					if (!word_ok(sp)) begin
						st = STS_BADADDR;
					end else begin
						exitv = vm_mem[sp[14:3]];
						vm_halted = 1'b1;
						st = STS_HALT;
					end
				end
				default: st = STS_BADOP;
			endcase
		end
		vm_pc = npc;
		r.acc = vm_acc;
		r.sp = vm_sp[15:0];
		r.npc = npc[15:0];
		r.exitv = exitv;
		r.status = st;
	endtask

	// sends one instruction item, idling between bursts
	task automatic send(input logic [5:0] op, input logic [63:0] imm);
		int gap;
		vm_result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, imm, op};
		do @(posedge clk); while (!s_tready);
		execute_instr(op, imm, r);
		pending_results.push_back(r);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// written only with the core idle; the wait covers a trailing multiply
	task automatic write_start_pc(input logic [15:0] v);
		drain();
		repeat (90) @(posedge clk);
		while (!s_tready) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vm_pc = {48'd0, v};
	endtask

	function automatic logic [63:0] rnd_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return WORD_MIN;
			3: return WORD_MAX;
			4: return 64'($urandom_range(0, 70));
			5: return -64'($urandom_range(1, 70));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic test_arith_extremes();
		write_start_pc(16'hffff);
		send(OP_IMM, WORD_MIN);      // pc wraps past the top of code space
		send(OP_PUSH, '0);
		send(OP_IMM, '1);
		send(OP_DIV, '0);            // most negative over minus one
		send(OP_PUSH, '0);
		send(OP_IMM, '1);
		send(OP_MOD, '0);
		send(OP_PUSH, '0);
		send(OP_MOD, '0);            // divide by zero leaves the stack alone
		send(OP_IMM, 64'd65);
		send(OP_SHL, '0);            // shift count taken mod 64
	endtask

	task automatic test_memory_edges();
		write_start_pc(16'd0);
		send(OP_IMM, 64'd32767);
		send(OP_LC, '0);
		send(OP_IMM, TOP);
		send(OP_LC, '0);
		send(OP_LI, '0);
		send(OP_IMM, 64'd8);
		send(OP_PUSH, '0);
		send(OP_IMM, 64'h80);
		send(OP_SC, '0);             // byte read back sign extended
		send(OP_ADJ, -64'd5000);
	endtask

	task automatic test_flow();
		send(OP_JMP, 64'd65536);
		send(OP_JMP, 64'd65535);
		send(OP_CALL, 64'd5);
		send(OP_ENT, 64'd2);
		send(OP_LEA, '1);
		send(OP_LEV, '0);
		send(OP_OPEN, '0);
		send(6'd63, '0);
	endtask

	task automatic refill_stack();
		if (vm_sp < 64'd4096)
			send(OP_ADJ, ((TOP - vm_sp) >> 3) - $urandom_range(4, 30));
	endtask

	task automatic test_random();
		logic [5:0]  op;
		logic [63:0] addr;
		int          n;
		write_start_pc(16'($urandom));
		while (items_sent < 610) begin
			if (items_sent == 400) write_start_pc(16'($urandom));
			refill_stack();
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					send(OP_IMM, rnd_word());
					send(OP_PUSH, '0);
					op = 6'($urandom_range(OP_OR, OP_MOD));
					send(OP_IMM, (op == OP_DIV || op == OP_MOD) && $urandom_range(0, 5) == 0
						? 64'd0 : rnd_word());
					send(op, rnd_word());
				end
				4, 5: begin
					addr = 64'($urandom_range(0, 32767));
					if ($urandom_range(0, 1)) addr[2:0] = 3'd0;
					send(OP_IMM, addr);
					send(OP_PUSH, '0);
					send(OP_IMM, rnd_word());
					send($urandom_range(0, 1) ? OP_SI : OP_SC, '0);
					send(OP_IMM, addr);
					send($urandom_range(0, 1) ? OP_LI : OP_LC, '0);
				end
				6: begin
					send(OP_CALL, 64'($urandom_range(0, 65535)));
					send(OP_ENT, 64'($urandom_range(0, 4)));
					n = $urandom_range(0, 3);
					repeat (n) begin
						send(OP_LEA, 64'($urandom_range(0, 6)) - 64'd3);
						send(OP_PUSH, '0);
					end
					send(OP_LEV, '0);
				end
				7: begin
					send(OP_IMM, $urandom_range(0, 1) ? 64'd0 : rnd_word());
					send(6'($urandom_range(0, 2) == 0 ? OP_JMP : ($urandom_range(0, 1) ?
						OP_JZ : OP_JNZ)), $urandom_range(0, 3) == 0 ? rnd_word()
						: 64'($urandom_range(0, 65535)));
				end
				8: send(OP_ADJ, $urandom_range(0, 4) == 0 ? rnd_word()
					: 64'($urandom_range(0, 8)) - 64'd4);
				default: begin
					do op = 6'($urandom); while (op == OP_EXIT);
					send(op, rnd_word());
				end
			endcase
		end
	endtask

	task automatic test_halt();
		drain();                     // sender holds off until every result is in
		send(OP_ADJ, (TOP - vm_sp) >> 3);
		send(OP_EXIT, '0);           // empty stack: bad address, no halt
		send(OP_IMM, 64'd77);
		send(OP_PUSH, '0);
		send(OP_EXIT, '0);
		send(OP_IMM, '1);
		send(OP_PUSH, '0);
	endtask

	initial begin
		vm_acc = '0; vm_sp = TOP; vm_bp = TOP; vm_pc = '0; vm_halted = 1'b0;
		for (int i = 0; i < 4096; i++) vm_mem[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_arith_extremes();
		test_memory_edges();
		test_flow();
		test_random();
		test_halt();
		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
